// ----- sv/sed_pkg.sv -----
package sed_pkg;

  // Depth of the decision histories unless the top level overrides it.
  localparam int MAX_WINDOW_DEF = 256;

  // An 8-bit window register can never reach more than this many slots.
  localparam int WINDOW_SPAN = 256;

  localparam int WIN_W = 8;

  // Register reset values.
  localparam logic [WIN_W-1:0] START_WINDOW_RST = 8'd25;
  localparam logic [WIN_W-1:0] END_WINDOW_RST   = 8'd25;

  // Register indexes on the configuration port.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_START_WINDOW  = 2'd0;
  localparam cfg_index_t REG_END_WINDOW    = 2'd1;
  localparam cfg_index_t REG_END_ONLY_MODE = 2'd2;

  // Result codes.
  typedef logic [1:0] event_t;
  localparam event_t EV_NONE  = 2'd0;
  localparam event_t EV_START = 2'd1;
  localparam event_t EV_END   = 2'd2;

  // Majority test: count * PCT_SCALE >= PCT_THRESH * window.
  localparam int PCT_SCALE  = 100;
  localparam int PCT_THRESH = 81;

  // Test spacing in frames.
  localparam int CHECK_SHORT = 5;
  localparam int CHECK_LONG  = 10;

endpackage

// ----- sv/speech_endpoint_detector.sv -----
// Each accepted frame gets one result beat; a tested frame first counts the active
// window of W frames, and a detected event then clears its history with a sweep
// over all HIST_DEPTH slots (at most 256).
// Only one frame is in flight: no new input beat is taken until the result beat
// of the last frame is issued, which waits on a stalled result beat.
// Reset is synchronous, then a sweep over all HIST_DEPTH history slots holds off input.
module speech_endpoint_detector #(
  parameter int MAX_WINDOW = sed_pkg::MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  sed_pkg::cfg_index_t cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                frame_is_speech,
  input  logic                frame_failed,
  output logic                out_valid,
  input  logic                out_ready,
  output sed_pkg::event_t     event_res
);
  import sed_pkg::*;

  localparam int HIST_DEPTH = (MAX_WINDOW < WINDOW_SPAN) ? MAX_WINDOW : WINDOW_SPAN;
  localparam int AW = $clog2(HIST_DEPTH);
  localparam int PW = 15;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_COUNT, S_MUL, S_CMP, S_CLEAR, S_POST
  } state_t;

  state_t state;

  logic [WIN_W-1:0] start_window, end_window;
  logic             end_only_mode;
  logic             speaking;
  logic [7:0]       ring_position;
  logic [3:0]       check_phase;
  logic [7:0]       frames_seen;

  logic [WIN_W-1:0] win;
  logic             use_end;
  logic             end_only;
  logic [7:0]       k;
  logic             issue;
  logic [7:0]       cnt;
  logic [PW-1:0]    prod_cnt, prod_win;
  logic [AW-1:0]    clr_addr;
  logic             clr_start, clr_end;
  event_t           ev;

  logic start_hist [HIST_DEPTH];
  logic end_hist   [HIST_DEPTH];
  logic rd_start, rd_end;

  // Decode for the frame being accepted.
  logic             acc;
  logic             use_end_now;
  logic [WIN_W-1:0] raw_win, win_now;
  logic [8:0]       pos_inc;
  logic [7:0]       pos_next;
  logic [3:0]       phase_next;
  logic [7:0]       seen_next;
  logic             test_now;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    use_end_now = end_only_mode || speaking;
    raw_win     = use_end_now ? end_window : start_window;
    if (raw_win == '0) begin
      win_now = WIN_W'(1);
    end else if (32'(raw_win) > MAX_WINDOW) begin
      win_now = WIN_W'(MAX_WINDOW);
    end else begin
      win_now = raw_win;
    end
    pos_inc    = {1'b0, ring_position} + 9'd1;
    pos_next   = (pos_inc >= {1'b0, win_now}) ? 8'd0 : pos_inc[7:0];
    phase_next = (check_phase >= 4'(CHECK_LONG - 1)) ? 4'd0 : check_phase + 4'd1;
    seen_next  = (frames_seen == 8'hFF) ? frames_seen : frames_seen + 8'd1;
    test_now   = (seen_next >= win_now) &&
                 ((phase_next == 4'd0) ||
                  (!end_only_mode && phase_next == 4'(CHECK_SHORT)));
  end

  // Write ports: the accepted frame, or the clearing sweep.
  logic          st_we, en_we, st_wd, en_wd;
  logic [AW-1:0] st_wa, en_wa;
  logic          rd_en;

  always_comb begin
    st_we = 1'b0;
    en_we = 1'b0;
    st_wa = pos_next[AW-1:0];
    en_wa = pos_next[AW-1:0];
    st_wd = frame_is_speech;
    en_wd = frame_is_speech;
    if (acc && !frame_failed) begin
      st_we = !use_end_now;
      en_we = use_end_now;
    end else if (state == S_INIT || state == S_CLEAR) begin
      st_we = clr_start;
      en_we = clr_end;
      st_wa = clr_addr;
      en_wa = clr_addr;
      st_wd = 1'b0;
      en_wd = 1'b1;
    end
    rd_en = (state == S_COUNT) && (k != win);
  end

  always_ff @(posedge clk) begin
    if (st_we) start_hist[st_wa] <= st_wd;
    if (en_we) end_hist[en_wa] <= en_wd;
    if (rd_en) begin
      rd_start <= start_hist[k[AW-1:0]];
      rd_end   <= end_hist[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_window  <= START_WINDOW_RST;
      end_window    <= END_WINDOW_RST;
      end_only_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_WINDOW:  start_window  <= cfg_data;
        REG_END_WINDOW:    end_window    <= cfg_data;
        REG_END_ONLY_MODE: end_only_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      speaking      <= 1'b0;
      ring_position <= '0;
      check_phase   <= '0;
      frames_seen   <= '0;
      out_valid     <= 1'b0;
      clr_addr      <= '0;
      clr_start     <= 1'b1;
      clr_end       <= 1'b1;
      issue         <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_POST) out_valid <= 1'b0;
      unique case (state)
        S_INIT, S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(HIST_DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= (state == S_INIT) ? S_IDLE : S_POST;
          end
        end
        S_IDLE: begin
          if (acc) begin
            ring_position <= pos_next;
            check_phase   <= phase_next;
            frames_seen   <= seen_next;
            win           <= win_now;
            use_end       <= use_end_now;
            end_only      <= end_only_mode;
            ev            <= EV_NONE;
            k             <= '0;
            cnt           <= '0;
            issue         <= 1'b0;
            state         <= (!frame_failed && test_now) ? S_COUNT : S_POST;
          end
        end
        S_COUNT: begin
          // One slot is read per cycle; its bit is registered in rd_start and rd_end.
          if (k != win) begin
            k     <= k + 8'd1;
            issue <= 1'b1;
          end else begin
            issue <= 1'b0;
          end
          if (issue && (use_end ? !rd_end : rd_start)) cnt <= cnt + 8'd1;
          if (k == win && !issue) state <= S_MUL;
        end
        S_MUL: begin
          prod_cnt <= PW'(cnt) * PW'(PCT_SCALE);
          prod_win <= PW'(win) * PW'(PCT_THRESH);
          state    <= S_CMP;
        end
        S_CMP: begin
          if (prod_cnt >= prod_win) begin
            ring_position <= '0;
            check_phase   <= '0;
            frames_seen   <= '0;
            clr_addr      <= '0;
            if (use_end) begin
              ev        <= EV_END;
              clr_start <= 1'b0;
              clr_end   <= 1'b1;
              if (!end_only) speaking <= 1'b0;
            end else begin
              ev        <= EV_START;
              clr_start <= 1'b1;
              clr_end   <= 1'b0;
              speaking  <= 1'b1;
            end
            state <= S_CLEAR;
          end else begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            event_res <= ev;
            state     <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

// ----- sv/sed_checker.sv -----
module sed_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input sed_pkg::event_t event_res
);
  import sed_pkg::*;

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("result beat changed while stalled");

  // Only one frame is in flight: the block is busy right after a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a frame is in progress");

  // The history sweep after reset holds off input.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("input ready or result shown during the reset sweep");

endmodule

bind speech_endpoint_detector sed_checker u_sed_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .event_res (event_res)
);

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  typedef struct packed {
    logic   speech;
    logic   failed;
    logic   typed;
    event_t ev;
  } frame_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  cfg_index_t cfg_index = REG_START_WINDOW;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       frame_is_speech = 1'b0;
  logic       frame_failed = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  event_t     event_res;

  speech_endpoint_detector dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .frame_is_speech, .frame_failed,
    .out_valid, .out_ready, .event_res
  );

  always #1 clk = ~clk;

  // Shadow copy of the detector state.
  logic [7:0] start_win_m;
  logic [7:0] end_win_m;
  logic       end_only_m;
  logic       speaking_m;
  logic       start_hist [0:MAX_WINDOW_DEF-1];
  logic       end_hist [0:MAX_WINDOW_DEF-1];
  int         ring_pos;
  int         phase_cnt;
  int         seen_cnt;

  event_t     expected_events [$];
  event_t     oldest_event;
  int         mismatches = 0;
  bit         steady = 1'b0;

  // With the rows below the start window is 1 frame and the end window 2.
  frame_row_t directed_rows [22] = '{
    '{1'b1, 1'b1, 1'b1, EV_NONE},
    '{1'b0, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b0, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b1, EV_START},
    '{1'b0, 1'b0, 1'b0, EV_NONE},
    '{1'b0, 1'b0, 1'b0, EV_NONE},
    '{1'b0, 1'b0, 1'b0, EV_NONE},
    '{1'b0, 1'b0, 1'b0, EV_NONE},
    '{1'b0, 1'b0, 1'b1, EV_END},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b0, 1'b1, 1'b1, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b0, EV_NONE},
    '{1'b1, 1'b0, 1'b1, EV_START},
    '{1'b0, 1'b1, 1'b1, EV_NONE},
    '{1'b1, 1'b1, 1'b1, EV_NONE}
  };

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic event_t predict_endpoint(input logic speech, input logic failed);
    logic   use_end;
    logic   wanted;
    int     w;
    int     cnt;
    int     k;
    event_t ev;
    use_end = end_only_m || speaking_m;
    w = use_end ? int'(end_win_m) : int'(start_win_m);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
    ev = EV_NONE;
    ring_pos = (ring_pos + 1 >= w) ? 0 : ring_pos + 1;
    phase_cnt = (phase_cnt + 1 >= CHECK_LONG) ? 0 : phase_cnt + 1;
    if (seen_cnt < 255) seen_cnt++;
    if (failed) return EV_NONE;
    if (use_end) end_hist[ring_pos] = speech;
    else start_hist[ring_pos] = speech;
    if (seen_cnt >= w && (phase_cnt == 0 || (!end_only_m && phase_cnt == CHECK_SHORT))) begin
      // A start counts speech frames, an end counts silent ones.
      wanted = !use_end;
      cnt = 0;
      for (k = 0; k < w; k++) begin
        if ((use_end ? end_hist[k] : start_hist[k]) == wanted) cnt++;
      end
      if (cnt * PCT_SCALE >= PCT_THRESH * w) begin
        if (use_end) begin
          ev = EV_END;
          if (!end_only_m) speaking_m = 1'b0;
          for (k = 0; k < MAX_WINDOW_DEF; k++) end_hist[k] = 1'b1;
        end else begin
          ev = EV_START;
          speaking_m = 1'b1;
          for (k = 0; k < MAX_WINDOW_DEF; k++) start_hist[k] = 1'b0;
        end
        ring_pos = 0;
        phase_cnt = 0;
        seen_cnt = 0;
      end
    end
    return ev;
  endfunction

  function automatic logic [7:0] pick_window(input bit wide);
    logic [7:0] w;
    if (wide) begin
      case ($urandom_range(0, 2))
        0: w = 8'd150;
        1: w = 8'd200;
        default: w = 8'd255;
      endcase
    end else if ($urandom_range(0, 5) == 0) begin
      w = 8'($urandom_range(0, 2));
    end else begin
      w = 8'($urandom_range(2, 30));
    end
    return w;
  endfunction

  // Called on a falling edge; returns on the falling edge after the beat.
  task automatic send_frame(input logic speech, input logic failed, input logic typed,
                            input event_t typed_ev);
    int     gap;
    event_t ev;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_is_speech <= speech;
    frame_failed <= failed;
    do @(posedge clk); while (!in_ready);
    ev = predict_endpoint(speech, failed);
    expected_events.push_back(typed ? typed_ev : ev);
    @(negedge clk);
  endtask

  // Holds the sender off until every result is back and the block takes input again.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_events.size() != 0 || !in_ready);
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [7:0] sw, input logic [7:0] ew, input logic eo);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_WINDOW;
    cfg_data <= sw;
    @(negedge clk);
    cfg_index <= REG_END_WINDOW;
    cfg_data <= ew;
    @(negedge clk);
    cfg_index <= REG_END_ONLY_MODE;
    cfg_data <= {7'd0, eo};
    @(negedge clk);
    cfg_we <= 1'b0;
    start_win_m = sw;
    end_win_m = ew;
    end_only_m = eo;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, event_res %0d", event_res));
      end else begin
        oldest_event = expected_events.pop_front();
        if (event_res !== oldest_event)
          report_mismatch($sformatf("event_res %0d, expected %0d", event_res, oldest_event));
      end
    end
  end

  // Result side: a fresh stall is drawn before every beat.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int         sent;
    int         phase;
    int         len;
    int         seg;
    int         bias;
    int         i;
    bit         wide;
    frame_row_t row;
    start_win_m = START_WINDOW_RST;
    end_win_m = END_WINDOW_RST;
    end_only_m = 1'b0;
    speaking_m = 1'b0;
    for (i = 0; i < MAX_WINDOW_DEF; i++) begin
      start_hist[i] = 1'b0;
      end_hist[i] = 1'b1;
    end
    ring_pos = 0;
    phase_cnt = 0;
    seen_cnt = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // A start window of zero behaves as a single frame.
    write_regs(8'd0, 8'd2, 1'b0);
    foreach (directed_rows[j]) begin
      row = directed_rows[j];
      send_frame(row.speech, row.failed, row.typed, row.ev);
    end
    sent = $size(directed_rows);

    for (phase = 0; sent < 1700; phase++) begin
      wide = (phase == 0) || ($urandom_range(0, 7) == 0);
      wait_idle();
      // The widest windows come first so that the frame counter saturates early.
      if (phase == 0) write_regs(8'd255, 8'd255, 1'b0);
      else write_regs(pick_window(wide), pick_window(wide), $urandom_range(0, 2) == 0);
      steady = ($urandom_range(0, 3) == 0);
      len = wide ? $urandom_range(300, 340) : $urandom_range(30, 100);
      if (len > 1700 - sent) len = 1700 - sent;
      while (len > 0) begin
        seg = wide ? $urandom_range(40, 160) : $urandom_range(5, 60);
        case ($urandom_range(0, 5))
          0: bias = 100;
          1: bias = 95;
          2: bias = 85;
          3: bias = 50;
          4: bias = 10;
          default: bias = 0;
        endcase
        for (i = 0; i < seg && len > 0; i++) begin
          send_frame($urandom_range(0, 99) < bias, $urandom_range(0, 24) == 0,
                     1'b0, EV_NONE);
          len--;
          sent++;
        end
      end
    end

    wait_idle();
    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sed_pkg.sv
sv/speech_endpoint_detector.sv
sv/sed_checker.sv
verif/tb.sv
